// ===== sv/psd_pkg.sv =====
// ----------------------------------------------------------------------------
// psd_pkg
// Shared widths, payload types, register codes and helpers for the
// primitive signed distance unit.
// ----------------------------------------------------------------------------
package psd_pkg;

    localparam int COORD_W    = 32;               // coordinate width, signed
    localparam int FRAC_W     = 16;               // fraction bits
    localparam int LANES      = 3;                // one lane per axis
    localparam int DIFF_W     = COORD_W + 1;      // p - c, signed
    localparam int Q_W        = DIFF_W + 1;       // box offset q, signed
    localparam int PROD_W     = 2 * DIFF_W;       // lane product, unsigned
    localparam int SUM_W      = PROD_W + 3;       // signed sum of three products
    localparam int ROOT_W     = DIFF_W;           // square root width
    localparam int RAD_W      = 2 * ROOT_W;       // radicand width
    localparam int REM_W      = ROOT_W + 2;       // root remainder width
    localparam int OFS_W      = Q_W;              // offset added to the root
    localparam int FIN_W      = ROOT_W + 2;       // root plus offset, signed
    localparam int RADIUS_W   = COORD_W - 1;
    localparam int CFG_ADDR_W = 4;

    localparam logic signed [COORD_W-1:0] DIST_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] DIST_MIN = {1'b1, {(COORD_W-1){1'b0}}};
    localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(1) << FRAC_W;

    typedef enum logic [1:0] {
        SHAPE_SPHERE = 2'd0,
        SHAPE_PLANE  = 2'd1,
        SHAPE_BOX    = 2'd2
    } shape_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_SHAPE_KIND = 4'd0,
        REG_CENTER_X   = 4'd1,
        REG_CENTER_Y   = 4'd2,
        REG_CENTER_Z   = 4'd3,
        REG_VEC_X      = 4'd4,
        REG_VEC_Y      = 4'd5,
        REG_VEC_Z      = 4'd6,
        REG_RADIUS     = 4'd7
    } cfg_reg_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] point_z;
    } in_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] distance;
        logic                      saturated;
    } out_t;

    // per-axis result of one lane
    typedef struct packed {
        logic [PROD_W-1:0]     prod;
        logic                  neg;
        logic signed [Q_W-1:0] q;
    } lane_t;

    // data that rides along with the root pipeline
    typedef struct packed {
        logic signed [OFS_W-1:0] ofs;
        logic [COORD_W-1:0]      pdist;
        logic                    psat;
    } side_t;

    // pipeline control between stages
    typedef struct packed {
        logic adv;
        logic vld;
    } pipe_ctl_t;

    function automatic logic [DIFF_W-1:0] mag_f(input logic signed [DIFF_W-1:0] x);
        return x[DIFF_W-1] ? DIFF_W'(-x) : DIFF_W'(x);
    endfunction

endpackage

// ===== sv/psd_lane.sv =====
// ----------------------------------------------------------------------------
// psd_lane
// One axis lane: offset from the center, magnitudes, box offset and the
// lane product (square or normal product), three pipeline stages.
// ----------------------------------------------------------------------------
module psd_lane (
    input  logic                         aclk,
    input  logic                         adv,
    input  logic [1:0]                   kind,
    input  logic [psd_pkg::COORD_W-1:0]  point,
    input  logic [psd_pkg::COORD_W-1:0]  center,
    input  logic [psd_pkg::COORD_W-1:0]  vec,
    output psd_pkg::lane_t               res
);
    import psd_pkg::*;

    logic signed [DIFF_W-1:0] d_reg, d_next;
    logic signed [DIFF_W-1:0] vc_reg, vc_next;
    logic [DIFF_W-1:0]        a_reg, a_next;
    logic [DIFF_W-1:0]        b_reg, b_next;
    logic                     negb_reg, negb_next;
    logic signed [Q_W-1:0]    qb_reg, qb_next;
    logic [PROD_W-1:0]        prod_reg, prod_next;
    logic                     negc_reg;
    logic signed [Q_W-1:0]    qc_reg;
    logic [DIFF_W-1:0]        dm, vm, nm;

    // stage a: offsets from the center
    always_comb begin
        d_next  = DIFF_W'($signed(point)) - DIFF_W'($signed(center));
        vc_next = DIFF_W'($signed(vec)) - DIFF_W'($signed(center));
    end

    // stage b: magnitudes, box offset, multiplier operands
    always_comb begin
        dm      = mag_f(d_reg);
        vm      = mag_f(vc_reg);
        nm      = mag_f(DIFF_W'($signed(vec)));
        qb_next = $signed({1'b0, dm}) - $signed({1'b0, vm});
        if (kind == SHAPE_BOX) begin
            a_next = (qb_next > 0) ? qb_next[DIFF_W-1:0] : '0;
        end else begin
            a_next = dm;
        end
        b_next    = (kind == SHAPE_PLANE) ? nm : a_next;
        negb_next = (kind == SHAPE_PLANE) && (d_reg[DIFF_W-1] ^ vec[COORD_W-1]);
    end

    // stage c: lane product
    assign prod_next = PROD_W'(a_reg) * PROD_W'(b_reg);

    always_ff @(posedge aclk) begin
        if (adv) begin
            d_reg    <= d_next;
            vc_reg   <= vc_next;
            a_reg    <= a_next;
            b_reg    <= b_next;
            negb_reg <= negb_next;
            qb_reg   <= qb_next;
            prod_reg <= prod_next;
            negc_reg <= negb_reg;
            qc_reg   <= qb_reg;
        end
    end

    assign res.prod = prod_reg;
    assign res.neg  = negc_reg;
    assign res.q    = qc_reg;

endmodule

// ===== sv/psd_merge.sv =====
// ----------------------------------------------------------------------------
// psd_merge
// Combines the three lanes: signed sum of products, largest box offset,
// plane magnitude with saturation, and the radicand for the root.
// ----------------------------------------------------------------------------
module psd_merge (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  psd_pkg::pipe_ctl_t          ctl,
    input  logic [1:0]                  kind,
    input  logic [psd_pkg::RADIUS_W-1:0] radius,
    input  psd_pkg::lane_t              lanes [psd_pkg::LANES],
    output logic                        out_valid,
    output logic [psd_pkg::RAD_W-1:0]   rad,
    output psd_pkg::side_t              side
);
    import psd_pkg::*;

    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic signed [Q_W-1:0]   top_reg, top_next;
    logic                    vd_reg, ve_reg;
    logic [RAD_W-1:0]        rad_reg;
    side_t                   side_reg, side_next;
    logic signed [SUM_W-1:0] term [LANES];
    logic [SUM_W-1:0]        absv;
    logic                    psat;

    // stage d: signed sum and largest box offset, capped at zero
    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            term[i] = lanes[i].neg ? -$signed(SUM_W'(lanes[i].prod))
                                   : $signed(SUM_W'(lanes[i].prod));
        end
        sum_next = term[0] + term[1] + term[2];
        top_next = lanes[0].q;
        if (lanes[1].q > top_next) top_next = lanes[1].q;
        if (lanes[2].q > top_next) top_next = lanes[2].q;
        if (top_next > 0) top_next = '0;
    end

    // stage e: plane magnitude and root offset
    always_comb begin
        absv = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
        psat = |absv[SUM_W-1:FRAC_W+COORD_W-1];
        side_next.psat  = psat;
        side_next.pdist = psat ? DIST_MAX : {1'b0, absv[FRAC_W+COORD_W-2:FRAC_W]};
        side_next.ofs   = (kind == SHAPE_SPHERE) ? -$signed({{(OFS_W-RADIUS_W){1'b0}}, radius})
                                                 : top_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vd_reg <= 1'b0;
            ve_reg <= 1'b0;
        end else if (ctl.adv) begin
            vd_reg <= ctl.vld;
            ve_reg <= vd_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.adv) begin
            sum_reg  <= sum_next;
            top_reg  <= top_next;
            rad_reg  <= sum_reg[RAD_W-1:0];
            side_reg <= side_next;
        end
    end

    assign out_valid = ve_reg;
    assign rad       = rad_reg;
    assign side      = side_reg;

endmodule

// ===== sv/psd_sqrt.sv =====
// ----------------------------------------------------------------------------
// psd_sqrt
// Pipelined integer square root, one root bit per stage, floor result.
// Carries side data along with each transaction.
// ----------------------------------------------------------------------------
module psd_sqrt (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  psd_pkg::pipe_ctl_t         ctl,
    input  logic [psd_pkg::RAD_W-1:0]  rad,
    input  psd_pkg::side_t             side_in,
    output logic                       out_valid,
    output logic [psd_pkg::ROOT_W-1:0] root,
    output psd_pkg::side_t             side_out
);
    import psd_pkg::*;

    logic              v_reg    [ROOT_W];
    logic [RAD_W-1:0]  n_reg    [ROOT_W];
    logic [REM_W-1:0]  rem_reg  [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];
    side_t             side_reg [ROOT_W];

    logic              v_src    [ROOT_W];
    logic [RAD_W-1:0]  n_src    [ROOT_W];
    logic [REM_W-1:0]  rem_src  [ROOT_W];
    logic [ROOT_W-1:0] root_src [ROOT_W];
    side_t             side_src [ROOT_W];

    logic [RAD_W-1:0]  n_next    [ROOT_W];
    logic [REM_W-1:0]  rem_next  [ROOT_W];
    logic [ROOT_W-1:0] root_next [ROOT_W];
    logic [REM_W-1:0]  rem_sh    [ROOT_W];
    logic [REM_W-1:0]  trial     [ROOT_W];

    // stage sources
    always_comb begin
        v_src[0]    = ctl.vld;
        n_src[0]    = rad;
        rem_src[0]  = '0;
        root_src[0] = '0;
        side_src[0] = side_in;
        for (int k = 1; k < ROOT_W; k++) begin
            v_src[k]    = v_reg[k-1];
            n_src[k]    = n_reg[k-1];
            rem_src[k]  = rem_reg[k-1];
            root_src[k] = root_reg[k-1];
            side_src[k] = side_reg[k-1];
        end
    end

    // one restoring step per stage
    always_comb begin
        for (int k = 0; k < ROOT_W; k++) begin
            rem_sh[k] = {rem_src[k][REM_W-3:0], n_src[k][RAD_W-1:RAD_W-2]};
            trial[k]  = {root_src[k], 2'b01};
            n_next[k] = {n_src[k][RAD_W-3:0], 2'b00};
            if (rem_sh[k] >= trial[k]) begin
                rem_next[k]  = rem_sh[k] - trial[k];
                root_next[k] = {root_src[k][ROOT_W-2:0], 1'b1};
            end else begin
                rem_next[k]  = rem_sh[k];
                root_next[k] = {root_src[k][ROOT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < ROOT_W; k++) v_reg[k] <= 1'b0;
        end else if (ctl.adv) begin
            for (int k = 0; k < ROOT_W; k++) v_reg[k] <= v_src[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.adv) begin
            for (int k = 0; k < ROOT_W; k++) begin
                n_reg[k]    <= n_next[k];
                rem_reg[k]  <= rem_next[k];
                root_reg[k] <= root_next[k];
                side_reg[k] <= side_src[k];
            end
        end
    end

    assign out_valid = v_reg[ROOT_W-1];
    assign root      = root_reg[ROOT_W-1];
    assign side_out  = side_reg[ROOT_W-1];

endmodule

// ===== sv/primitive_signed_distance_unit.sv =====
// ----------------------------------------------------------------------------
// primitive_signed_distance_unit
// Distance from a Q16.16 query point to one configured sphere, plane or box.
// ----------------------------------------------------------------------------
// Takes one point per cycle while s_ready is high and returns one distance per
// point, in order. Each point passes through the per-axis lanes (offset,
// operands, multiply), the merge stage, the square root pipeline (one root
// bit per stage) and the output register.
// A two-entry output buffer lets the pipeline keep taking points while one
// result waits; s_ready drops only when both entries are full. Configuration
// writes are always accepted and must only be issued while the unit is idle.
module primitive_signed_distance_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  psd_pkg::in_t                   s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output psd_pkg::out_t                  m_data,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [psd_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [psd_pkg::COORD_W-1:0]    cfg_data
);
    import psd_pkg::*;

    logic [1:0]          kind_reg;
    logic [COORD_W-1:0]  center_reg [LANES];
    logic [COORD_W-1:0]  vec_reg    [LANES];
    logic [RADIUS_W-1:0] radius_reg;

    logic [COORD_W-1:0]  point [LANES];
    lane_t               lanes [LANES];
    logic [2:0]          lv_reg;
    logic                adv;
    pipe_ctl_t           merge_ctl, sqrt_ctl;
    logic                merge_valid, sqrt_valid;
    logic [RAD_W-1:0]    rad;
    side_t               side_m, side_s;
    logic [ROOT_W-1:0]   root;

    logic signed [FIN_W-1:0] fin;
    out_t                res;
    out_t                out_reg, skid_reg;
    logic                out_v_reg, skid_v_reg;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kind_reg   <= SHAPE_SPHERE;
            for (int i = 0; i < LANES; i++) begin
                center_reg[i] <= '0;
                vec_reg[i]    <= '0;
            end
            radius_reg <= RADIUS_RESET;
        end else if (cfg_valid) begin
            case (cfg_addr)
                REG_SHAPE_KIND: kind_reg      <= cfg_data[1:0];
                REG_CENTER_X:   center_reg[0] <= cfg_data;
                REG_CENTER_Y:   center_reg[1] <= cfg_data;
                REG_CENTER_Z:   center_reg[2] <= cfg_data;
                REG_VEC_X:      vec_reg[0]    <= cfg_data;
                REG_VEC_Y:      vec_reg[1]    <= cfg_data;
                REG_VEC_Z:      vec_reg[2]    <= cfg_data;
                REG_RADIUS:     radius_reg    <= cfg_data[RADIUS_W-1:0];
                default: ;
            endcase
        end
    end

    // pipeline advances while the output buffer has room
    assign adv     = !skid_v_reg;
    assign s_ready = adv;

    assign point[0] = s_data.point_x;
    assign point[1] = s_data.point_y;
    assign point[2] = s_data.point_z;

    // axis lanes
    for (genvar i = 0; i < LANES; i++) begin : g_lane
        psd_lane u_lane (
            .aclk   (aclk),
            .adv    (adv),
            .kind   (kind_reg),
            .point  (point[i]),
            .center (center_reg[i]),
            .vec    (vec_reg[i]),
            .res    (lanes[i])
        );
    end

    // lane stage valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lv_reg <= '0;
        end else if (adv) begin
            lv_reg <= {lv_reg[1:0], s_valid};
        end
    end

    assign merge_ctl.adv = adv;
    assign merge_ctl.vld = lv_reg[2];

    psd_merge u_merge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (merge_ctl),
        .kind      (kind_reg),
        .radius    (radius_reg),
        .lanes     (lanes),
        .out_valid (merge_valid),
        .rad       (rad),
        .side      (side_m)
    );

    assign sqrt_ctl.adv = adv;
    assign sqrt_ctl.vld = merge_valid;

    psd_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (sqrt_ctl),
        .rad       (rad),
        .side_in   (side_m),
        .out_valid (sqrt_valid),
        .root      (root),
        .side_out  (side_s)
    );

    // final add, clip and shape select
    always_comb begin
        fin = $signed({2'b00, root}) + FIN_W'(side_s.ofs);
        case (kind_reg)
            SHAPE_SPHERE, SHAPE_BOX: begin
                if (fin > FIN_W'(DIST_MAX)) begin
                    res.distance  = DIST_MAX;
                    res.saturated = 1'b1;
                end else if (fin < FIN_W'(DIST_MIN)) begin
                    res.distance  = DIST_MIN;
                    res.saturated = 1'b1;
                end else begin
                    res.distance  = fin[COORD_W-1:0];
                    res.saturated = 1'b0;
                end
            end
            SHAPE_PLANE: begin
                res.distance  = side_s.pdist;
                res.saturated = side_s.psat;
            end
            default: begin
                res.distance  = '0;
                res.saturated = 1'b0;
            end
        endcase
    end

    // output register with skid entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end else begin
            if (skid_v_reg) begin
                if (m_ready) begin
                    skid_v_reg <= 1'b0;
                end
            end else if (sqrt_valid) begin
                if (out_v_reg && !m_ready) begin
                    skid_v_reg <= 1'b1;
                end else begin
                    out_v_reg <= 1'b1;
                end
            end else if (m_ready) begin
                out_v_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_v_reg) begin
            if (m_ready) out_reg <= skid_reg;
        end else if (sqrt_valid) begin
            if (out_v_reg && !m_ready) skid_reg <= res;
            else                       out_reg  <= res;
        end
    end

    assign m_valid = out_v_reg;
    assign m_data  = out_reg;

endmodule

// ===== sv/psd_checker.sv =====
// ----------------------------------------------------------------------------
// psd_checker
// Port-level checks of the primitive signed distance unit, bound to the top.
// ----------------------------------------------------------------------------
module psd_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_valid,
    input logic                           s_ready,
    input psd_pkg::in_t                   s_data,
    input logic                           m_valid,
    input logic                           m_ready,
    input psd_pkg::out_t                  m_data,
    input logic                           cfg_valid,
    input logic                           cfg_ready,
    input logic [psd_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input logic [psd_pkg::COORD_W-1:0]    cfg_data
);
    import psd_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // no result straight out of reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // a clipped distance sits at a range limit
    a_sat_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.saturated |->
            (m_data.distance == DIST_MAX) || (m_data.distance == DIST_MIN))
        else $error("saturated flag without clipped distance");

    // input backpressure only while a result is waiting
    a_ready_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input stalled with no pending result");

endmodule

bind primitive_signed_distance_unit psd_checker u_psd_checker (.*);
